// ===== rtl/pmbm_pkg.sv =====
// Package for the priority mailbox buffer manager: word types, result codes,
// sizing constants. No dependencies.
`timescale 1ns / 1ps
package pmbm_pkg;
	localparam int BUFFERS_DEF = 4;
	localparam int SWAIT_DEPTH_DEF = 8;
	localparam int RWAIT_DEPTH_DEF = 8;
	localparam int REQUESTERS_DEF = 16;
	localparam int PRIOS = 3;

	localparam logic OP_SEND = 1'b0;
	localparam logic OP_RECV = 1'b1;

	localparam logic [2:0] K_SEND_DONE = 3'd0;
	localparam logic [2:0] K_SEND_WAIT = 3'd1;
	localparam logic [2:0] K_SEND_REJ  = 3'd2;
	localparam logic [2:0] K_DELIVER   = 3'd3;
	localparam logic [2:0] K_RECV_WAIT = 3'd4;
	localparam logic [2:0] K_RECV_REJ  = 3'd5;

	typedef struct packed {
		logic              op;
		logic [3:0]        requester;
		logic [1:0]        sender_priority;
		logic signed [31:0] message;
	} in_word_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [3:0]        target;
		logic signed [31:0] data_out;
		logic [1:0]        buffer_used;
		logic              last;
	} out_word_t;
endpackage

// ===== rtl/pmbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pmbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/priority_mailbox_buffer_manager.sv =====
// Priority mailbox buffer manager, top level. Uses pmbm_pkg and pmbm_ram.
// Each operation passes through the states read, resolve and out; a second
// result, if any, follows the first once that one is taken. in_stall holds
// new operations off until the last result is taken, so only one operation is
// in flight, and out_stall holds the results. Reset (arst_n low)
// rebuilds the free list and empties every queue at once; no clearing pass.
`timescale 1ns / 1ps
module priority_mailbox_buffer_manager #(
	parameter int BUFFERS = pmbm_pkg::BUFFERS_DEF,
	parameter int SENDER_WAIT_DEPTH = pmbm_pkg::SWAIT_DEPTH_DEF,
	parameter int RECEIVER_WAIT_DEPTH = pmbm_pkg::RWAIT_DEPTH_DEF,
	parameter int REQUESTERS = pmbm_pkg::REQUESTERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pmbm_pkg::in_word_t in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output pmbm_pkg::out_word_t out_data
);
	import pmbm_pkg::*;

	// buffer index width; null is the value BUFFERS
	localparam int BW = $clog2(BUFFERS + 1);
	localparam int BA = $clog2(BUFFERS > 1 ? BUFFERS : 2);
	localparam int SA = $clog2(SENDER_WAIT_DEPTH > 1 ? SENDER_WAIT_DEPTH : 2);
	localparam int SC = $clog2(SENDER_WAIT_DEPTH + 1);
	localparam int RA = $clog2(RECEIVER_WAIT_DEPTH > 1 ? RECEIVER_WAIT_DEPTH : 2);
	localparam int RC = $clog2(RECEIVER_WAIT_DEPTH + 1);
	localparam int SQ = PRIOS * SENDER_WAIT_DEPTH;
	// one wait RAM: sender queues first, receiver queue after them
	localparam int WQ = SQ + RECEIVER_WAIT_DEPTH;
	localparam int WQA = $clog2(WQ);
	localparam logic [BW-1:0] NULLB = BW'(BUFFERS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_RES  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	in_word_t   req_q;

	// link table is small control state, kept in flops
	logic [BW-1:0] link_q [BUFFERS];
	logic [BW-1:0] full_head_q, full_tail_q, free_head_q;
	logic [SC-1:0] scnt_q [PRIOS];
	logic [SA-1:0] shead_q [PRIOS];
	logic [RC-1:0] rcnt_q;
	logic [RA-1:0] rhead_q;

	// second result pending
	out_word_t second_q;
	logic      has2_q;

	// memories
	logic          ms_we;
	logic [BA-1:0] ms_wa, ms_ra;
	logic [31:0]   ms_wd, ms_rd;
	logic           wq_we;
	logic [WQA-1:0] wq_wa, wq_ra;
	logic [35:0]    wq_wd, wq_rd;

	pmbm_ram #(.WIDTH(32), .DEPTH(BUFFERS)) u_msg (
		.clk, .we(ms_we), .waddr(ms_wa), .wdata(ms_wd), .raddr(ms_ra), .rdata(ms_rd));
	pmbm_ram #(.WIDTH(36), .DEPTH(WQ)) u_wait (
		.clk, .we(wq_we), .waddr(wq_wa), .wdata(wq_wd), .raddr(wq_ra), .rdata(wq_rd));

	function automatic logic isb(input logic [BW-1:0] b);
		return b < NULLB;
	endfunction

	function automatic logic [SA-1:0] sinc(input logic [SA-1:0] a, input logic [SC-1:0] n);
		logic [SC:0] s;
		s = {1'b0, (SC)'(a)} + {1'b0, n};
		if (s >= (SC + 1)'(SENDER_WAIT_DEPTH))
			s = s - (SC + 1)'(SENDER_WAIT_DEPTH);
		return s[SA-1:0];
	endfunction

	function automatic logic [RA-1:0] rinc(input logic [RA-1:0] a, input logic [RC-1:0] n);
		logic [RC:0] s;
		s = {1'b0, (RC)'(a)} + {1'b0, n};
		if (s >= (RC + 1)'(RECEIVER_WAIT_DEPTH))
			s = s - (RC + 1)'(RECEIVER_WAIT_DEPTH);
		return s[RA-1:0];
	endfunction

	// decode of the held request, valid from ST_READ on
	logic          is_send, bad, sblocked, any_s;
	logic [1:0]    pw;          // priority of the sender to wake (lowest-numbered nonempty queue)
	logic [BW-1:0] fb, hb;
	always_comb begin
		is_send = req_q.op == OP_SEND;
		bad = 32'(req_q.requester) >= REQUESTERS ||
			(is_send && req_q.sender_priority >= 2'(PRIOS));
		sblocked = !isb(free_head_q);
		for (int p = 0; p < PRIOS; p++)
			if (p <= int'(req_q.sender_priority) && scnt_q[p] != '0)
				sblocked = 1'b1;
		any_s = 1'b0;
		pw = 2'd0;
		for (int p = PRIOS - 1; p >= 0; p--)
			if (scnt_q[p] != '0) begin
				any_s = 1'b1;
				pw = 2'(p);
			end
		fb = free_head_q;
		hb = full_head_q;
	end

	// read addresses come from the held request, sampled at the end of ST_READ;
	// a send only needs the receiver head, a receive only the woken sender
	always_comb begin
		ms_ra = hb[BA-1:0];
		if (is_send)
			wq_ra = WQA'(SQ + 32'(rhead_q));
		else
			wq_ra = WQA'(32'(pw) * SENDER_WAIT_DEPTH + 32'(shead_q[pw]));
	end

	logic [SC-1:0] cp;
	logic [SA-1:0] sidx;
	assign cp = scnt_q[req_q.sender_priority];
	assign sidx = sinc(shead_q[req_q.sender_priority], cp);

	out_word_t r1, r2;
	logic      two;
	logic [BW-1:0] nxt;
	always_comb begin
		ms_we = 1'b0; ms_wa = fb[BA-1:0]; ms_wd = req_q.message;
		wq_we = 1'b0;
		if (is_send)
			wq_wa = WQA'(32'(req_q.sender_priority) * SENDER_WAIT_DEPTH + 32'(sidx));
		else
			wq_wa = WQA'(SQ + 32'(rinc(rhead_q, rcnt_q)));
		wq_wd = {req_q.requester, req_q.message};
		r1 = '0; r2 = '0; two = 1'b0;
		r1.target = req_q.requester; r1.last = 1'b1;
		nxt = NULLB;
		if (bad) begin
			r1.kind = is_send ? K_SEND_REJ : K_RECV_REJ;
		end else if (is_send) begin
			if (sblocked) begin
				if (32'(cp) >= SENDER_WAIT_DEPTH)
					r1.kind = K_SEND_REJ;
				else begin
					r1.kind = K_SEND_WAIT;
					wq_we = state_q == ST_RES;
				end
			end else begin
				ms_we = state_q == ST_RES;
				r1.kind = K_SEND_DONE;
				r1.data_out = req_q.message;
				r1.buffer_used = 2'(fb);
				if (rcnt_q != '0) begin
					r1.last = 1'b0;
					two = 1'b1;
					r2.kind = K_DELIVER;
					r2.target = wq_rd[35:32];
					r2.data_out = req_q.message;
					r2.buffer_used = 2'(fb);
					r2.last = 1'b1;
				end
			end
		end else begin
			if (!isb(hb)) begin
				if (32'(rcnt_q) >= RECEIVER_WAIT_DEPTH)
					r1.kind = K_RECV_REJ;
				else begin
					r1.kind = K_RECV_WAIT;
					wq_we = state_q == ST_RES;
				end
			end else begin
				nxt = isb(link_q[hb[BA-1:0]]) ? link_q[hb[BA-1:0]] : NULLB;
				r1.kind = K_DELIVER;
				r1.data_out = ms_rd;
				r1.buffer_used = 2'(hb);
				if (any_s) begin
					r1.last = 1'b0;
					two = 1'b1;
					ms_we = state_q == ST_RES;
					ms_wa = hb[BA-1:0];
					ms_wd = wq_rd[31:0];
					r2.kind = K_SEND_DONE;
					r2.target = wq_rd[35:32];
					r2.data_out = wq_rd[31:0];
					r2.buffer_used = 2'(hb);
					r2.last = 1'b1;
				end
			end
		end
	end

	assign in_stall = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			has2_q <= 1'b0;
			for (int i = 0; i < BUFFERS; i++)
				link_q[i] <= BW'(i + 1);
			full_head_q <= NULLB;
			full_tail_q <= NULLB;
			free_head_q <= '0;
			for (int p = 0; p < PRIOS; p++) begin
				scnt_q[p] <= '0;
				shead_q[p] <= '0;
			end
			rcnt_q <= '0;
			rhead_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_RES;
				ST_RES: begin
					out_valid <= 1'b1;
					has2_q <= two;
					state_q <= ST_OUT;
					if (!bad && is_send && sblocked && 32'(cp) < SENDER_WAIT_DEPTH)
						scnt_q[req_q.sender_priority] <= cp + 1'b1;
					else if (!bad && is_send && !sblocked) begin
						if (rcnt_q != '0) begin
							// handoff: buffer stays at free head
							rhead_q <= rinc(rhead_q, RC'(1));
							rcnt_q <= rcnt_q - 1'b1;
						end else begin
							free_head_q <= isb(link_q[fb[BA-1:0]]) ?
								link_q[fb[BA-1:0]] : NULLB;
							link_q[fb[BA-1:0]] <= NULLB;
							if (!isb(full_head_q) || !isb(full_tail_q))
								full_head_q <= fb;
							else
								link_q[full_tail_q[BA-1:0]] <= fb;
							full_tail_q <= fb;
						end
					end else if (!bad && !is_send && !isb(hb)) begin
						if (32'(rcnt_q) < RECEIVER_WAIT_DEPTH)
							rcnt_q <= rcnt_q + 1'b1;
					end else if (!bad && !is_send) begin
						if (any_s) begin
							shead_q[pw] <= sinc(shead_q[pw], SC'(1));
							scnt_q[pw] <= scnt_q[pw] - 1'b1;
							// re-append hb at tail of list after removal
							link_q[hb[BA-1:0]] <= NULLB;
							if (!isb(nxt)) begin
								full_head_q <= hb;
							end else begin
								full_head_q <= nxt;
								link_q[full_tail_q[BA-1:0]] <= hb;
							end
							full_tail_q <= hb;
						end else begin
							full_head_q <= nxt;
							if (!isb(nxt))
								full_tail_q <= NULLB;
							link_q[hb[BA-1:0]] <= free_head_q;
							free_head_q <= hb;
						end
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						if (has2_q)
							has2_q <= 1'b0;
						else begin
							out_valid <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid)
			req_q <= in_data;
		if (state_q == ST_RES) begin
			out_data <= r1;
			second_q <= r2;
		end else if (state_q == ST_OUT && !out_stall && has2_q)
			out_data <= second_q;
	end

`ifndef NO_ASSERTIONS
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT) else $error("result outside output phase");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has2_q |-> !out_data.last) else $error("first of two marked last");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has2_q |-> out_data.last) else $error("final result not last");
	a_rcnt: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rcnt_q) <= RECEIVER_WAIT_DEPTH) else $error("receiver count overflow");
`endif
endmodule

// ===== dv/priority_mailbox_buffer_manager_tb.sv =====
// Testbench for the priority mailbox buffer manager: directed and random
// send/receive words checked against a behavioral mailbox predictor.
// Depends on pmbm_pkg and the priority_mailbox_buffer_manager RTL.
`timescale 1ns / 1ps
module priority_mailbox_buffer_manager_tb;
	import pmbm_pkg::*;

	localparam int NBUF = BUFFERS_DEF;
	localparam int SDEPTH = SWAIT_DEPTH_DEF;
	localparam int RDEPTH = RWAIT_DEPTH_DEF;
	localparam int NULL_BUF = NBUF;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_data;
	logic out_valid;
	logic out_stall;
	out_word_t out_data;

	priority_mailbox_buffer_manager dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mailbox shadow state.
	logic [31:0] mb_store [NBUF];
	int mb_link [NBUF];
	int full_hd, full_tl, free_hd;
	logic [3:0] snd_who [PRIOS][SDEPTH];
	logic [31:0] snd_msg [PRIOS][SDEPTH];
	int snd_cnt [PRIOS];
	int snd_hd [PRIOS];
	logic [3:0] rcv_who [RDEPTH];
	int rcv_cnt, rcv_hd;

	out_word_t pending_results[$];
	int errors = 0;
	int idle_cycles = 0;
	int sent_words = 0;

	task automatic report_mismatch(input string what, input out_word_t got,
			input out_word_t exp);
		errors++;
		$display("MISMATCH %s: got k=%0d t=%0d d=%h b=%0d l=%0d exp k=%0d t=%0d d=%h b=%0d l=%0d",
			what, got.kind, got.target, got.data_out, got.buffer_used, got.last,
			exp.kind, exp.target, exp.data_out, exp.buffer_used, exp.last);
	endtask

	function automatic out_word_t mk(logic [2:0] k, logic [3:0] t, logic [31:0] d,
			int b, logic l);
		out_word_t r;
		r.kind = k;
		r.target = t;
		r.data_out = d;
		r.buffer_used = b[1:0];
		r.last = l;
		return r;
	endfunction

	function automatic void mailbox_reset();
		for (int i = 0; i < NBUF; i++) begin
			mb_link[i] = i + 1;
			mb_store[i] = '0;
		end
		full_hd = NULL_BUF;
		full_tl = NULL_BUF;
		free_hd = 0;
		for (int p = 0; p < PRIOS; p++) begin
			snd_cnt[p] = 0;
			snd_hd[p] = 0;
		end
		rcv_cnt = 0;
		rcv_hd = 0;
	endfunction

	function automatic int nxt(int b);
		return (b < NBUF) ? b : NULL_BUF;
	endfunction

	function automatic void link_full(int b);
		mb_link[b] = NULL_BUF;
		if (full_hd >= NBUF || full_tl >= NBUF)
			full_hd = b;
		else
			mb_link[full_tl] = b;
		full_tl = b;
	endfunction

	// Predicts the results of one word and advances the shadow state.
	function automatic void predict_mailbox(in_word_t w);
		int b, p;
		logic blocked;
		logic [31:0] d;
		logic [3:0] who;
		if (w.op == OP_SEND) begin
			if (w.sender_priority >= PRIOS) begin
				pending_results.push_back(mk(K_SEND_REJ, w.requester, 0, 0, 1'b1));
				return;
			end
			blocked = (free_hd >= NBUF);
			for (p = 0; p <= w.sender_priority; p++)
				if (snd_cnt[p] != 0)
					blocked = 1'b1;
			if (blocked) begin
				p = w.sender_priority;
				if (snd_cnt[p] >= SDEPTH) begin
					pending_results.push_back(mk(K_SEND_REJ, w.requester, 0, 0, 1'b1));
					return;
				end
				snd_who[p][(snd_hd[p] + snd_cnt[p]) % SDEPTH] = w.requester;
				snd_msg[p][(snd_hd[p] + snd_cnt[p]) % SDEPTH] = w.message;
				snd_cnt[p]++;
				pending_results.push_back(mk(K_SEND_WAIT, w.requester, 0, 0, 1'b1));
				return;
			end
			b = free_hd;
			free_hd = nxt(mb_link[b]);
			mb_store[b] = w.message;
			if (rcv_cnt != 0) begin
				who = rcv_who[rcv_hd];
				rcv_hd = (rcv_hd + 1) % RDEPTH;
				rcv_cnt--;
				mb_link[b] = free_hd;
				free_hd = b;
				pending_results.push_back(mk(K_SEND_DONE, w.requester, w.message, b, 1'b0));
				pending_results.push_back(mk(K_DELIVER, who, w.message, b, 1'b1));
				return;
			end
			link_full(b);
			pending_results.push_back(mk(K_SEND_DONE, w.requester, w.message, b, 1'b1));
		end else begin
			if (full_hd >= NBUF) begin
				if (rcv_cnt >= RDEPTH) begin
					pending_results.push_back(mk(K_RECV_REJ, w.requester, 0, 0, 1'b1));
					return;
				end
				rcv_who[(rcv_hd + rcv_cnt) % RDEPTH] = w.requester;
				rcv_cnt++;
				pending_results.push_back(mk(K_RECV_WAIT, w.requester, 0, 0, 1'b1));
				return;
			end
			b = full_hd;
			full_hd = nxt(mb_link[b]);
			if (full_hd >= NBUF)
				full_tl = NULL_BUF;
			d = mb_store[b];
			for (p = 0; p < PRIOS; p++) begin
				if (snd_cnt[p] != 0) begin
					who = snd_who[p][snd_hd[p]];
					mb_store[b] = snd_msg[p][snd_hd[p]];
					snd_hd[p] = (snd_hd[p] + 1) % SDEPTH;
					snd_cnt[p]--;
					link_full(b);
					pending_results.push_back(mk(K_DELIVER, w.requester, d, b, 1'b0));
					pending_results.push_back(mk(K_SEND_DONE, who, mb_store[b], b, 1'b1));
					return;
				end
			end
			mb_link[b] = free_hd;
			free_hd = b;
			pending_results.push_back(mk(K_DELIVER, w.requester, d, b, 1'b1));
		end
	endfunction

	// Sends one word; predicts at acceptance. Bursts and gaps come from callers.
	task automatic send_word(input in_word_t w);
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_mailbox(w);
		sent_words++;
	endtask

	task automatic idle_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic in_word_t rand_word(int recv_pct, int prio3_pct);
		in_word_t w;
		w.op = ($urandom_range(99) < recv_pct) ? OP_RECV : OP_SEND;
		w.requester = 4'($urandom_range(15));
		w.sender_priority = ($urandom_range(99) < prio3_pct) ? 2'd3 : 2'($urandom_range(2));
		w.message = $urandom;
		return w;
	endfunction

	function automatic in_word_t word(logic o, int r, int p, logic [31:0] m);
		in_word_t w;
		w.op = o;
		w.requester = 4'(r);
		w.sender_priority = 2'(p);
		w.message = m;
		return w;
	endfunction

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Directed: extremes, waits, handoff, wake-up by priority, rejects.
	task automatic test_directed();
		send_word(word(OP_RECV, 0, 0, 0));                 // receiver waits
		send_word(word(OP_SEND, 15, 0, 32'h8000_0000));    // direct handoff
		send_word(word(OP_SEND, 3, 3, 32'h1234_5678));     // priority three
		for (int i = 0; i < NBUF; i++)                     // fill the pool
			send_word(word(OP_SEND, i, 2, (i == 0) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF));
		send_word(word(OP_SEND, 9, 2, 32'h0));             // no buffer: waits
		send_word(word(OP_SEND, 10, 0, 32'h5555_AAAA));    // higher priority waits
		send_word(word(OP_SEND, 11, 1, 32'hAAAA_5555));
		send_word(word(OP_RECV, 15, 1, 32'hFFFF_FFFF));    // wakes prio 0 sender
		send_word(word(OP_RECV, 14, 2, 0));                // wakes prio 1
		send_word(word(OP_RECV, 13, 0, 0));                // wakes prio 2
		for (int i = 0; i < NBUF + 1; i++)                 // drain, then one waits
			send_word(word(OP_RECV, i, 0, 0));
		wait_results_drained();
	endtask

	// Overflow both wait queues to reach the reject paths.
	task automatic test_queue_full();
		for (int i = 0; i < RDEPTH; i++)
			send_word(word(OP_RECV, i, 0, 0));  // one waiter already queued
		for (int i = 0; i < RDEPTH + 1; i++)
			send_word(word(OP_SEND, i, 1, $urandom));
		for (int i = 0; i < NBUF; i++)
			send_word(word(OP_SEND, i, 1, $urandom));
		for (int i = 0; i < SDEPTH + 1; i++)
			send_word(word(OP_SEND, i, 1, $urandom));
		// sender pauses until every result has come
		wait_results_drained();
		for (int i = 0; i < SDEPTH + NBUF + 1; i++)
			send_word(word(OP_RECV, i, 0, 0));
		wait_results_drained();
	endtask

	// Random traffic in bursts; mix drifts so queues fill and empty.
	task automatic test_random(input int total);
		int n, recv_pct;
		n = 0;
		while (n < total) begin
			recv_pct = $urandom_range(20, 80);
			repeat ($urandom_range(1, 24)) begin
				send_word(rand_word(recv_pct, 5));
				n++;
			end
			if ($urandom_range(3) != 0)
				idle_gap($urandom_range(1, 12));
		end
	endtask

	// Receiver stall pattern: long free-flow stretches and stall runs.
	initial begin
		int mode;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(2);
			repeat ($urandom_range(5, 60)) begin
				@(posedge clk);
				if (mode == 0)
					out_stall <= 1'b0;
				else if (mode == 1)
					out_stall <= ($urandom_range(1) == 0);
				else
					out_stall <= ($urandom_range(7) != 0);
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		out_word_t exp;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected", out_data, out_data);
			end else begin
				exp = pending_results.pop_front();
				if (out_data.kind !== exp.kind)
					report_mismatch("kind", out_data, exp);
				else if (out_data.target !== exp.target)
					report_mismatch("target", out_data, exp);
				else if (out_data.data_out !== exp.data_out)
					report_mismatch("data_out", out_data, exp);
				else if (out_data.buffer_used !== exp.buffer_used)
					report_mismatch("buffer_used", out_data, exp);
				else if (out_data.last !== exp.last)
					report_mismatch("last", out_data, exp);
			end
		end
	end

	// Watchdog: cycles with no accepted word on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		mailbox_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_queue_full();
		test_random(1000);
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
